@@ hdl/mvt_pkg.sv @@
// Shared constants and types for the 4x4 matrix-vector transform unit.
package mvt_pkg;

  localparam int DIMENSION  = 4;
  localparam int ROWS       = 4;
  localparam int COEF_W     = 16;
  localparam int VEC_W      = 32;
  localparam int ROW_W      = ROWS * COEF_W;
  localparam int FRAC_SHIFT = 12;
  localparam int PROD_W     = COEF_W + VEC_W;
  localparam int ACC_W      = PROD_W + $clog2(DIMENSION);
  localparam int CFG_IDX_W  = $clog2(ROWS);

  typedef struct packed {
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;
    logic signed [VEC_W-1:0] vec_w;
  } vec_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] out_x;
    logic signed [VEC_W-1:0] out_y;
    logic signed [VEC_W-1:0] out_z;
    logic signed [VEC_W-1:0] out_w;
    logic                    overflow;
  } res_t;

  typedef logic [DIMENSION-1:0][COEF_W-1:0] coef_col_t;

  typedef logic [ROWS-1:0][ROW_W-1:0] matrix_t;

  typedef struct packed {
    logic [DIMENSION-1:0][VEC_W-1:0] comp;
    logic [DIMENSION-1:0][ACC_W-1:0] acc;
  } cell_data_t;

endpackage

@@ hdl/mvt_cell.sv @@
// One column cell: multiply-accumulate of one vector component into every row sum.
module mvt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  mvt_pkg::cell_data_t up_data,
  input  mvt_pkg::coef_col_t  coef,
  output logic                dn_valid,
  input  logic                dn_ready,
  output mvt_pkg::cell_data_t dn_data
);
  import mvt_pkg::*;

  logic                     valid_r;
  cell_data_t               data_r;
  cell_data_t               data_nxt;
  logic signed [VEC_W-1:0]  vec_s;
  logic signed [COEF_W-1:0] coef_s [DIMENSION];
  logic signed [PROD_W-1:0] prod   [DIMENSION];

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;
  assign vec_s    = $signed(up_data.comp[0]);

  always_comb begin
    for (int i = 0; i < DIMENSION - 1; i++) begin
      data_nxt.comp[i] = up_data.comp[i+1];
    end
    data_nxt.comp[DIMENSION-1] = '0;
    for (int r = 0; r < DIMENSION; r++) begin
      coef_s[r] = $signed(coef[r]);
      prod[r]   = coef_s[r] * vec_s;
      data_nxt.acc[r] = ACC_W'($signed(up_data.acc[r]) + ACC_W'(prod[r]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ hdl/mvt_sat.sv @@
// Output stage: floor shift, saturation, overflow flag and result register.
module mvt_sat (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  mvt_pkg::cell_data_t up_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mvt_pkg::res_t       out_data
);
  import mvt_pkg::*;

  localparam int Q_W = ACC_W - FRAC_SHIFT;
  localparam logic [VEC_W-1:0] SAT_MAX = {1'b0, {(VEC_W-1){1'b1}}};
  localparam logic [VEC_W-1:0] SAT_MIN = {1'b1, {(VEC_W-1){1'b0}}};

  logic                        out_valid_r;
  res_t                        out_data_r;
  res_t                        res_nxt;
  logic [ROWS-1:0][VEC_W-1:0]  val;
  logic [ROWS-1:0]             ovf;

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    if (r < DIMENSION) begin : g_live
      logic [Q_W-1:0]     q;
      logic [Q_W-VEC_W:0] hi;
      assign q  = up_data.acc[r][ACC_W-1:FRAC_SHIFT];
      assign hi = q[Q_W-1:VEC_W-1];
      assign ovf[r] = !((&hi) || !(|hi));
      assign val[r] = !ovf[r] ? q[VEC_W-1:0] : (q[Q_W-1] ? SAT_MIN : SAT_MAX);
    end else begin : g_dead
      assign ovf[r] = 1'b0;
      assign val[r] = '0;
    end
  end

  always_comb begin
    res_nxt.out_x    = val[0];
    res_nxt.out_y    = val[1];
    res_nxt.out_z    = val[2];
    res_nxt.out_w    = val[3];
    res_nxt.overflow = |ovf;
  end

  assign up_ready  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

@@ hdl/matrix4x4_vector_transform.sv @@
// Top level of the 4x4 matrix-vector transform unit.
//
// Usage: load the four matrix rows through the cfg_ port (cfg_index picks the
// row, cfg_wdata holds four signed Q4.12 coefficients, column 0 lowest) while
// no request is in flight. Then stream vectors (signed Q16.16) on the in_
// channel; each request yields one result on the out_ channel: the four row
// dot products, floor-shifted right by 12 and saturated to 32 bits, plus an
// overflow flag.
// Throughput: one request per cycle while out_stall is low. A request moves
// through the cells in order, then the saturation register drives out_valid.
// There are five registers: one per column cell of the chain (four
// multiply-accumulate cells, each with four 16x32 multipliers) plus the
// saturation register. The first cell loads at the accepting edge.
// Reset clears all matrix rows to zero and empties the chain.
// When the receiver stalls, the result holds on out_data and the chain keeps
// filling its empty stages; in_stall rises only once every stage holds a
// request.
module matrix4x4_vector_transform (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mvt_pkg::vec_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mvt_pkg::res_t                     out_data,
  input  logic                              cfg_we,
  input  logic [mvt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mvt_pkg::ROW_W-1:0]         cfg_wdata
);
  import mvt_pkg::*;

  matrix_t                     matrix_r;
  coef_col_t                   col   [DIMENSION];
  logic [ROWS-1:0][VEC_W-1:0]  in_comp;
  logic                        valid [DIMENSION+1];
  logic                        ready [DIMENSION+1];
  cell_data_t                  data  [DIMENSION+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r <= '0;
    end else if (cfg_we) begin
      matrix_r[cfg_index] <= cfg_wdata;
    end
  end

  always_comb begin
    for (int c = 0; c < DIMENSION; c++) begin
      for (int r = 0; r < DIMENSION; r++) begin
        col[c][r] = matrix_r[r][COEF_W*c +: COEF_W];
      end
    end
  end

  assign in_comp = {in_data.vec_w, in_data.vec_z, in_data.vec_y, in_data.vec_x};

  always_comb begin
    data[0].acc = '0;
    for (int i = 0; i < DIMENSION; i++) begin
      data[0].comp[i] = in_comp[i];
    end
  end

  assign valid[0] = in_valid;
  assign in_stall = !ready[0];

  for (genvar c = 0; c < DIMENSION; c++) begin : g_cell
    mvt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (valid[c]),
      .up_ready (ready[c]),
      .up_data  (data[c]),
      .coef     (col[c]),
      .dn_valid (valid[c+1]),
      .dn_ready (ready[c+1]),
      .dn_data  (data[c+1])
    );
  end

  mvt_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (valid[DIMENSION]),
    .up_ready  (ready[DIMENSION]),
    .up_data   (data[DIMENSION]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
